/* design/gaussian_blur_5x5_with_histogram_top_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the Gaussian blur with histogram block
// Shared property templates, clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef GAUSSIAN_BLUR_5X5_WITH_HISTOGRAM_TOP_DEFINES_SVH
`define GAUSSIAN_BLUR_5X5_WITH_HISTOGRAM_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GBH_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GBH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/gbh_pkg.sv */
// ----------------------------------------------------------------------------
// gbh_pkg
// Types, constants and helpers shared by the blur and histogram modules.
// ----------------------------------------------------------------------------
package gbh_pkg;

  localparam int unsigned WIN       = 5;
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned SUM_W     = 17;
  localparam int unsigned PROD_W    = 2 * SUM_W;
  localparam int unsigned DIV_SHIFT = 25;
  localparam int unsigned VAL_W     = PROD_W - DIV_SHIFT;
  localparam int unsigned BINS      = 256;
  localparam int unsigned BIN_W     = 8;
  localparam int unsigned CNT_PORT_W = 32;
  localparam int unsigned QDEPTH    = 4;
  localparam int unsigned QPTR_W    = 2;
  localparam int unsigned QCNT_W    = 3;
  localparam int unsigned LANES     = 4;

  // Reciprocal of 273 scaled by 2^25, rounded up; exact for sums up to 273*255.
  localparam logic [SUM_W-1:0] DIV_MULT = 17'd122911;
  localparam logic [VAL_W-1:0] PIX_MAX  = 9'd255;

  localparam logic [12:0] MIN_DIM    = 13'd5;
  localparam logic [12:0] MAX_HEIGHT = 13'd4096;
  localparam logic [11:0] HALF_WIN   = 12'd2;
  localparam logic [11:0] FULL_ROWS  = 12'd4;

  // Kernel is symmetric, so packed element order does not matter.
  localparam logic [WIN-1:0][WIN-1:0][5:0] KERNEL = {
    {6'd1, 6'd4,  6'd7,  6'd4,  6'd1},
    {6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
    {6'd7, 6'd26, 6'd41, 6'd26, 6'd7},
    {6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
    {6'd1, 6'd4,  6'd7,  6'd4,  6'd1}
  };

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  localparam logic [7:0] REG_IMAGE_WIDTH  = 8'd0;
  localparam logic [7:0] REG_IMAGE_HEIGHT = 8'd1;
  localparam logic [7:0] REG_ROW_FIRST    = 8'd2;
  localparam logic [7:0] REG_ROW_END      = 8'd3;

  typedef logic [WIN-1:0][WIN-1:0][PIX_W-1:0] win_t;

  typedef struct packed {
    logic [10:0] image_width;
    logic [12:0] image_height;
    logic [11:0] row_first;
    logic [11:0] row_end;
  } cfg_t;

  typedef struct packed {
    logic             func;
    logic [BIN_W-1:0] bin_index;
    logic             frame_done;
    win_t             win;
  } q_entry_t;

  typedef struct packed {
    logic [QCNT_W-1:0] level;
    logic              not_empty;
  } q_stat_t;

  function automatic logic [SUM_W-1:0] row_sum(input logic [WIN-1:0][PIX_W-1:0] px,
                                               input logic [2:0] r);
    logic [SUM_W-1:0] acc;
    acc = '0;
    for (int j = 0; j < WIN; j++) begin
      acc = acc + SUM_W'(px[j]) * SUM_W'(KERNEL[r][j]);
    end
    return acc;
  endfunction

endpackage

/* design/gbh_ifs.sv */
// ----------------------------------------------------------------------------
// gbh channel interfaces
// Request, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface gbh_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] pixel_in;
  logic [7:0] bin_index;
  modport source (output valid, func, pixel_in, bin_index, input ready);
  modport sink   (input valid, func, pixel_in, bin_index, output ready);
endinterface

interface gbh_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  blurred_pixel;
  logic [31:0] bin_count;
  logic        frame_done;
  modport source (output valid, blurred_pixel, bin_count, frame_done, input ready);
  modport sink   (input valid, blurred_pixel, bin_count, frame_done, output ready);
endinterface

interface gbh_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  reg_idx;
  logic [15:0] wdata;
  modport source (output valid, reg_idx, wdata, input ready);
  modport sink   (input valid, reg_idx, wdata, output ready);
endinterface

/* design/gbh_front.sv */
// ----------------------------------------------------------------------------
// gbh_front
// Accepts requests, tracks raster position, line stores and the 5x5 window.
// ----------------------------------------------------------------------------
module gbh_front #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  gbh_in_if.sink            in_ch,
  input  gbh_pkg::cfg_t     cfg_i,
  input  gbh_pkg::q_stat_t  q_stat_i,
  output logic              q_push_o,
  output gbh_pkg::q_entry_t q_entry_o
);
  import gbh_pkg::*;

  localparam int unsigned CIW = $clog2(MAX_WIDTH);
  localparam int unsigned WCW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned EW  = (WCW > 11) ? WCW : 11;
  localparam logic [EW-1:0] MAXW = EW'(MAX_WIDTH);
  localparam logic [EW-1:0] MINW = EW'(MIN_DIM);

  logic [LANES*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [LANES*PIX_W-1:0] line_rd_q;

  logic [CIW-1:0] col_q;
  logic [11:0]    row_q;

  logic             f1_v_q;
  logic             f1_func_q;
  logic [PIX_W-1:0] f1_pix_q;
  logic [BIN_W-1:0] f1_bin_q;
  logic [1:0]       f1_lane_q;
  logic             f1_emit_q;
  logic             f1_fd_q;

  win_t win_q, win_d;

  logic [EW-1:0]  w_raw, w_eff, col_ext, c_ext;
  logic [CIW-1:0] c_idx;
  logic [12:0]    h_eff;
  logic [11:0]    cr;
  logic           last_col, last_row, emit, accept, push_acc;

  assign in_ch.ready = ({1'b0, q_stat_i.level} + {{QCNT_W{1'b0}}, f1_v_q})
                       < (QCNT_W + 1)'(QDEPTH);
  assign accept   = in_ch.valid && in_ch.ready;
  assign push_acc = accept && (in_ch.func == FUNC_PUSH);

  always_comb begin
    w_raw = EW'(cfg_i.image_width);
    if (w_raw < MINW) begin
      w_eff = MINW;
    end else if (w_raw > MAXW) begin
      w_eff = MAXW;
    end else begin
      w_eff = w_raw;
    end
    if (cfg_i.image_height < MIN_DIM) begin
      h_eff = MIN_DIM;
    end else if (cfg_i.image_height > MAX_HEIGHT) begin
      h_eff = MAX_HEIGHT;
    end else begin
      h_eff = cfg_i.image_height;
    end
    col_ext  = EW'(col_q);
    c_ext    = (col_ext >= w_eff) ? (w_eff - EW'(1)) : col_ext;
    c_idx    = c_ext[CIW-1:0];
    last_col = (c_ext + EW'(1)) >= w_eff;
    last_row = ({1'b0, row_q} + 13'd1) >= h_eff;
    cr       = row_q - HALF_WIN;
    emit     = (row_q >= FULL_ROWS) && (c_ext >= EW'(FULL_ROWS))
               && (cr >= cfg_i.row_first) && (cr < cfg_i.row_end);
  end

  // Line store: one word per column, one byte lane per stored row.
  always_ff @(posedge clk_i) begin
    if (push_acc) begin
      line_rd_q <= line_mem[c_idx];
      line_mem[c_idx][row_q[1:0]*PIX_W +: PIX_W] <= in_ch.pixel_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      f1_v_q <= 1'b0;
    end else begin
      f1_v_q <= accept;
      if (push_acc) begin
        if (last_col) begin
          col_q <= '0;
          row_q <= last_row ? 12'd0 : (row_q + 12'd1);
        end else begin
          col_q <= c_idx + CIW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      f1_func_q <= in_ch.func;
      f1_pix_q  <= in_ch.pixel_in;
      f1_bin_q  <= in_ch.bin_index;
      f1_lane_q <= row_q[1:0];
      f1_emit_q <= emit;
      f1_fd_q   <= last_col && last_row;
    end
  end

  // The lane number wraps modulo four before it is scaled to a bit offset.
  always_comb begin
    win_d = win_q;
    for (int i = 0; i < WIN; i++) begin
      for (int j = 0; j < WIN - 1; j++) begin
        win_d[i][j] = win_q[i][j+1];
      end
    end
    for (int i = 0; i < LANES; i++) begin
      win_d[i][WIN-1] = line_rd_q[2'(f1_lane_q + 2'(i))*PIX_W +: PIX_W];
    end
    win_d[WIN-1][WIN-1] = f1_pix_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (f1_v_q && (f1_func_q == FUNC_PUSH)) begin
      win_q <= win_d;
    end
  end

  assign q_push_o = f1_v_q && ((f1_func_q == FUNC_READ) || f1_emit_q);
  always_comb begin
    q_entry_o.func       = f1_func_q;
    q_entry_o.bin_index  = f1_bin_q;
    q_entry_o.frame_done = f1_fd_q;
    q_entry_o.win        = win_d;
  end

endmodule

/* design/gbh_queue.sv */
// ----------------------------------------------------------------------------
// gbh_queue
// Short FIFO that decouples the window front end from the filter back end.
// ----------------------------------------------------------------------------
module gbh_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  gbh_pkg::q_entry_t entry_i,
  input  logic              pop_i,
  output gbh_pkg::q_entry_t head_o,
  output gbh_pkg::q_stat_t  stat_o
);
  import gbh_pkg::*;

  `include "gaussian_blur_5x5_with_histogram_top_defines.svh"

  q_entry_t            slots_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]   cnt_q;

  assign head_o           = slots_q[rd_ptr_q];
  assign stat_o.level     = cnt_q;
  assign stat_o.not_empty = (cnt_q != '0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

  `GBH_ASSERT_IMPL(a_no_overflow, push_i && (cnt_q == QCNT_W'(QDEPTH)), pop_i, "queue overflow")
  `GBH_ASSERT_IMPL(a_no_underflow, pop_i, cnt_q != '0, "queue underflow")
  `GBH_ASSERT_IMPL(a_level_bound, 1'b1, cnt_q <= QCNT_W'(QDEPTH), "queue level out of range")
  `GBH_ASSERT_NEXT(a_push_seen, push_i && !pop_i, cnt_q != '0, "pushed entry not counted")

endmodule

/* design/gbh_back.sv */
// ----------------------------------------------------------------------------
// gbh_back
// Kernel sum, divide by 273, histogram update or read, and result register.
// ----------------------------------------------------------------------------
module gbh_back #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gbh_pkg::q_entry_t head_i,
  input  gbh_pkg::q_stat_t  q_stat_i,
  output logic              pop_o,
  gbh_out_if.source         out_ch
);
  import gbh_pkg::*;

  logic advance;

  logic                       s1_v_q, s1_func_q, s1_fd_q;
  logic [BIN_W-1:0]           s1_bin_q;
  logic [WIN-1:0][SUM_W-1:0]  s1_rows_q;

  logic             s2_v_q, s2_func_q, s2_fd_q;
  logic [BIN_W-1:0] s2_bin_q;
  logic [SUM_W-1:0] s2_sum_q, sum_d;

  logic              s3_v_q, s3_func_q, s3_fd_q;
  logic [BIN_W-1:0]  s3_bin_q;
  logic [PROD_W-1:0] s3_prod_q;

  logic             s4_v_q, s4_func_q, s4_fd_q;
  logic [BIN_W-1:0] s4_addr_q;

  logic [COUNT_BITS-1:0] hist_mem [BINS];
  logic [BINS-1:0]       hist_vld_q;
  logic [COUNT_BITS-1:0] hist_rd_q, fwd_val_q, cnt_cur, cnt_new;
  logic                  hist_rd_vld_q, fwd_q;

  logic [VAL_W-1:0] quot;
  logic [BIN_W-1:0] addr_d;
  logic             hist_wr;

  logic                  out_v_q, out_fd_q;
  logic [PIX_W-1:0]      out_pix_q;
  logic [COUNT_BITS-1:0] out_cnt_q;

  assign advance = !out_v_q || out_ch.ready;
  assign pop_o   = advance && q_stat_i.not_empty;

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < WIN; i++) begin
      sum_d = sum_d + s1_rows_q[i];
    end
    quot   = s3_prod_q[PROD_W-1:DIV_SHIFT];
    addr_d = (s3_func_q == FUNC_READ) ? s3_bin_q
           : ((quot > PIX_MAX) ? BIN_W'(PIX_MAX) : quot[BIN_W-1:0]);
    cnt_cur = fwd_q ? fwd_val_q : (hist_rd_vld_q ? hist_rd_q : '0);
    cnt_new = ((s4_func_q == FUNC_PUSH) && !(&cnt_cur)) ? (cnt_cur + COUNT_BITS'(1))
                                                      : cnt_cur;
    hist_wr = advance && s4_v_q && (s4_func_q == FUNC_PUSH);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q     <= 1'b0;
      s2_v_q     <= 1'b0;
      s3_v_q     <= 1'b0;
      s4_v_q     <= 1'b0;
      out_v_q    <= 1'b0;
      hist_vld_q <= '0;
      fwd_q      <= 1'b0;
    end else if (advance) begin
      s1_v_q  <= pop_o;
      s2_v_q  <= s1_v_q;
      s3_v_q  <= s2_v_q;
      s4_v_q  <= s3_v_q;
      out_v_q <= s4_v_q;
      if (hist_wr) begin
        hist_vld_q[s4_addr_q] <= 1'b1;
      end
      fwd_q <= hist_wr && (s4_addr_q == addr_d);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      for (int i = 0; i < WIN; i++) begin
        s1_rows_q[i] <= row_sum(head_i.win[i], 3'(i));
      end
      s1_func_q <= head_i.func;
      s1_bin_q  <= head_i.bin_index;
      s1_fd_q   <= head_i.frame_done;

      s2_sum_q  <= sum_d;
      s2_func_q <= s1_func_q;
      s2_bin_q  <= s1_bin_q;
      s2_fd_q   <= s1_fd_q;

      s3_prod_q <= PROD_W'(s2_sum_q) * PROD_W'(DIV_MULT);
      s3_func_q <= s2_func_q;
      s3_bin_q  <= s2_bin_q;
      s3_fd_q   <= s2_fd_q;

      s4_addr_q     <= addr_d;
      s4_func_q     <= s3_func_q;
      s4_fd_q       <= s3_fd_q;
      hist_rd_q     <= hist_mem[addr_d];
      hist_rd_vld_q <= hist_vld_q[addr_d];
      fwd_val_q     <= cnt_new;

      out_pix_q <= (s4_func_q == FUNC_READ) ? '0 : s4_addr_q;
      out_cnt_q <= cnt_new;
      out_fd_q  <= (s4_func_q == FUNC_PUSH) && s4_fd_q;
    end
    if (hist_wr) begin
      hist_mem[s4_addr_q] <= cnt_new;
    end
  end

  assign out_ch.valid         = out_v_q;
  assign out_ch.blurred_pixel = out_pix_q;
  assign out_ch.bin_count     = CNT_PORT_W'(out_cnt_q);
  assign out_ch.frame_done    = out_fd_q;

endmodule

/* design/gaussian_blur_5x5_with_histogram_top.sv */
// ----------------------------------------------------------------------------
// gaussian_blur_5x5_with_histogram_top
// Streaming 5x5 Gaussian blur (weights total 273) with a 256-bin histogram.
// ----------------------------------------------------------------------------
// Channel   Direction  Carries
// in_ch     sink       func, pixel_in, bin_index (pixel push or bin read)
// out_ch    source     blurred_pixel, bin_count, frame_done
// cfg_ch    sink       reg_idx, wdata (image size and output row range)
//
// One request is taken every cycle while the output keeps draining; a result
// passes from its request through the front register, the queue, four back
// stages and the result register.
// The histogram read-modify-write runs in the last back stage with a bypass,
// so equal bins in consecutive results do not slow the stream.
// Reset clears the position, the window, the histogram valid bits and the
// registers; the line stores are left as they are and need no clearing pass.
// A stalled output freezes the back end; the four-entry queue then fills and
// input ready falls only once it cannot take the items already in flight.
// ----------------------------------------------------------------------------
module gaussian_blur_5x5_with_histogram_top #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  gbh_in_if.sink     in_ch,
  gbh_out_if.source  out_ch,
  gbh_cfg_if.sink    cfg_ch
);
  import gbh_pkg::*;

  cfg_t     cfg_q;
  q_stat_t  q_stat;
  q_entry_t q_entry, q_head;
  logic     q_push, q_pop;

  // Configuration writes are always taken; writes to unknown indexes are
  // accepted and dropped.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width  <= 11'd1024;
      cfg_q.image_height <= 13'd1024;
      cfg_q.row_first    <= 12'd2;
      cfg_q.row_end      <= 12'd1022;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.reg_idx)
        REG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_ch.wdata[10:0];
        REG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_ch.wdata[12:0];
        REG_ROW_FIRST:    cfg_q.row_first    <= cfg_ch.wdata[11:0];
        REG_ROW_END:      cfg_q.row_end      <= cfg_ch.wdata[11:0];
        default: begin
        end
      endcase
    end
  end

  // The front end follows the raster position, keeps the line stores and
  // the window, and queues only requests that will give a result.
  gbh_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ch     (in_ch),
    .cfg_i     (cfg_q),
    .q_stat_i  (q_stat),
    .q_push_o  (q_push),
    .q_entry_o (q_entry)
  );

  gbh_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_entry),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .stat_o  (q_stat)
  );

  // The back end forms the kernel sum, divides by a reciprocal multiply and
  // updates or reads the histogram before registering the result.
  gbh_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (q_head),
    .q_stat_i (q_stat),
    .pop_o    (q_pop),
    .out_ch   (out_ch)
  );

endmodule
